>>> sv/context_refcount_activity_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the context refcount activity table
// Concurrent checks, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CONTEXT_REFCOUNT_ACTIVITY_TABLE_ASSERT_SVH
`define CONTEXT_REFCOUNT_ACTIVITY_TABLE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define CRAT_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define CRAT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
// plain invariant
`define CRAT_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`else
`define CRAT_ASSERT_IMPL(name, clk, rst, ante, cons)
`define CRAT_ASSERT_NEXT(name, clk, rst, ante, cons)
`define CRAT_ASSERT(name, clk, rst, prop)
`endif

`endif

>>> sv/crat_pkg.sv
// ----------------------------------------------------------------------------
// crat_pkg
// Shared widths, command and status codes, and types of the context table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crat_pkg;

   localparam int DEF_ENTRIES = 16;
   localparam int DEF_KINDS   = 64;

   localparam int CMD_W    = 2;
   localparam int KEY_W    = 64;
   localparam int KIND_W   = 6;
   localparam int DELTA_W  = 8;
   localparam int COUNT_W  = 32;
   localparam int STATUS_W = 2;

   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 40;

   localparam logic [CMD_W-1:0] CMD_LOOKUP   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ENABLE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DISABLE  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_REFCOUNT = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]          command;
      logic [KEY_W-1:0]          context_key;
      logic [KIND_W-1:0]         activity_kind;
      logic signed [DELTA_W-1:0] count_delta;
   } cmd_info_type;

   typedef struct packed {
      logic                found;
      logic [COUNT_W-1:0]  ref_count;
      logic                inserted_flag;
      logic                enabled_flag;
      logic                removed;
      logic [STATUS_W-1:0] status;
   } result_type;

   typedef struct packed {
      logic wr_en;    // write the entry back
      logic alloc;    // mark the free slot valid
      logic drop;     // drop the matched slot
   } upd_ctl_type;

endpackage

`default_nettype wire

>>> sv/crat_ram.sv
// ----------------------------------------------------------------------------
// crat_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/crat_update.sv
// ----------------------------------------------------------------------------
// crat_update
// Modify step: applies one command to the matched or newly allocated entry
// and forms the result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crat_update #(
   parameter int KINDS = crat_pkg::DEF_KINDS
) (
   input  wire crat_pkg::cmd_info_type             info,
   input  wire logic                               hit,
   input  wire logic                               free_ok,
   input  wire logic [crat_pkg::COUNT_W-1:0]       old_count,
   input  wire logic [KINDS-1:0]                   old_ins,
   input  wire logic [KINDS-1:0]                   old_ena,
   output crat_pkg::upd_ctl_type                   ctl,
   output crat_pkg::result_type                    res,
   output logic      [crat_pkg::COUNT_W-1:0]       new_count,
   output logic      [KINDS-1:0]                   new_ins,
   output logic      [KINDS-1:0]                   new_ena
);

   logic [KINDS-1:0]                 mask;
   logic [crat_pkg::COUNT_W-1:0]     base_count;
   logic [KINDS-1:0]                 base_ins;
   logic [KINDS-1:0]                 base_ena;
   logic [crat_pkg::COUNT_W-1:0]     sum;

   // a kind at or above KINDS shifts out and yields an empty mask
   assign mask       = KINDS'(1) << info.activity_kind;
   assign base_count = hit ? old_count : '0;
   assign base_ins   = hit ? old_ins : '0;
   assign base_ena   = hit ? old_ena : '0;
   assign sum        = old_count + crat_pkg::COUNT_W'(info.count_delta);

   always_comb begin
      ctl       = '0;
      res       = '0;
      res.found = hit;
      new_count = base_count;
      new_ins   = base_ins;
      new_ena   = base_ena;
      unique case (info.command)
         crat_pkg::CMD_LOOKUP: begin
            if (hit) begin
               res.status        = crat_pkg::STAT_OK;
               res.ref_count     = old_count;
               res.inserted_flag = |(old_ins & mask);
               res.enabled_flag  = |(old_ena & mask);
            end else begin
               res.status = crat_pkg::STAT_NOTFOUND;
            end
         end
         crat_pkg::CMD_ENABLE, crat_pkg::CMD_DISABLE: begin
            if (hit || free_ok) begin
               if (info.command == crat_pkg::CMD_ENABLE) begin
                  new_ins = base_ins | mask;
                  new_ena = base_ena | mask;
               end else begin
                  new_ena = base_ena & ~mask;
               end
               ctl.wr_en         = 1'b1;
               ctl.alloc         = !hit;
               res.status        = crat_pkg::STAT_OK;
               res.ref_count     = base_count;
               res.inserted_flag = |(new_ins & mask);
               res.enabled_flag  = |(new_ena & mask);
            end else begin
               res.status = crat_pkg::STAT_FULL;
            end
         end
         crat_pkg::CMD_REFCOUNT: begin
            if (!hit) begin
               res.status = crat_pkg::STAT_NOTFOUND;
            end else if (sum == '0) begin
               ctl.drop    = 1'b1;
               res.removed = 1'b1;
               res.status  = crat_pkg::STAT_OK;
            end else begin
               new_count         = sum;
               ctl.wr_en         = 1'b1;
               res.status        = crat_pkg::STAT_OK;
               res.ref_count     = sum;
               res.inserted_flag = |(old_ins & mask);
               res.enabled_flag  = |(old_ena & mask);
            end
         end
         default: begin
            res.status = crat_pkg::STAT_NOTFOUND;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> sv/context_refcount_activity_table.sv
// Scan: the entry RAM has a single read port, so the key scan reads the entries
// one at a time, issuing the next read while the previous one is compared; it
// stops at the first hit, else covers every entry, and the update step then
// registers the result once the output register is free. One command at a time:
// the next request is taken the cycle after the result is registered.
// Reset: valid bits and control clear on the clock edge; RAM is not cleared.
// ----------------------------------------------------------------------------
// context_refcount_activity_table
// Keyed table of contexts with reference counts and per-activity flags,
// held in one RAM that is scanned per command; a changed entry is written back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module context_refcount_activity_table #(
   parameter int ENTRIES = crat_pkg::DEF_ENTRIES,
   parameter int KINDS   = crat_pkg::DEF_KINDS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // command[1:0], context_key[65:2], activity_kind[71:66], count_delta[79:72]
   input  wire logic [crat_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // found[0], ref_count[32:1], inserted_flag[33], enabled_flag[34],
   // removed[35], status[37:36], zero[39:38]
   output logic      [crat_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int ENT_W = crat_pkg::KEY_W + crat_pkg::COUNT_W + 2 * KINDS;
   localparam int CNT_LO = crat_pkg::KEY_W;
   localparam int INS_LO = crat_pkg::KEY_W + crat_pkg::COUNT_W;
   localparam int ENA_LO = INS_LO + KINDS;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   localparam logic [1:0] FSM_IDLE   = 2'd0;
   localparam logic [1:0] FSM_SCAN   = 2'd1;
   localparam logic [1:0] FSM_UPDATE = 2'd2;

   logic [1:0]             state_ff, state_in;
   crat_pkg::cmd_info_type info_ff, info_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                   issue_done_ff, issue_done_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]       cmp_idx_ff, cmp_idx_in;
   logic                   hit_ff, hit_in;
   logic [IDX_W-1:0]       hit_idx_ff, hit_idx_in;
   logic                   free_ok_ff, free_ok_in;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in;
   logic [ENT_W-1:0]       ent_ff, ent_in;
   logic [ENTRIES-1:0]     valid_ff, valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   crat_pkg::result_type   rsp_ff, rsp_in;

   logic                   req_fire;
   logic                   upd_go;
   logic                   ram_we;
   logic                   ram_re;
   logic [IDX_W-1:0]       ram_waddr;
   logic [ENT_W-1:0]       ram_wdata;
   logic [ENT_W-1:0]       ram_rdata;

   crat_pkg::upd_ctl_type        upd_ctl;
   crat_pkg::result_type         upd_res;
   logic [crat_pkg::COUNT_W-1:0] upd_count;
   logic [KINDS-1:0]             upd_ins;
   logic [KINDS-1:0]             upd_ena;

   assign req_tready = !reset && (state_ff == FSM_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.status, rsp_ff.removed, rsp_ff.enabled_flag,
                        rsp_ff.inserted_flag, rsp_ff.ref_count, rsp_ff.found};

   // commit only once the output register is free
   assign upd_go    = (state_ff == FSM_UPDATE) && (!rsp_valid_ff || rsp_tready);
   assign ram_re    = (state_ff == FSM_SCAN) && !issue_done_ff;
   assign ram_we    = upd_go && upd_ctl.wr_en;
   assign ram_waddr = hit_ff ? hit_idx_ff : free_idx_ff;
   assign ram_wdata = {upd_ena, upd_ins, upd_count, info_ff.context_key};

   crat_ram #(
      .WIDTH (ENT_W),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rdata)
   );

   crat_update #(
      .KINDS (KINDS)
   ) u_update (
      .info      (info_ff),
      .hit       (hit_ff),
      .free_ok   (free_ok_ff),
      .old_count (ent_ff[CNT_LO +: crat_pkg::COUNT_W]),
      .old_ins   (ent_ff[INS_LO +: KINDS]),
      .old_ena   (ent_ff[ENA_LO +: KINDS]),
      .ctl       (upd_ctl),
      .res       (upd_res),
      .new_count (upd_count),
      .new_ins   (upd_ins),
      .new_ena   (upd_ena)
   );

   always_comb begin
      state_in      = state_ff;
      info_in       = info_ff;
      rd_idx_in     = rd_idx_ff;
      issue_done_in = issue_done_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      free_ok_in    = free_ok_ff;
      free_idx_in   = free_idx_ff;
      ent_in        = ent_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         FSM_IDLE: begin
            if (req_fire) begin
               info_in.command       = req_tdata[1:0];
               info_in.context_key   = req_tdata[65:2];
               info_in.activity_kind = req_tdata[71:66];
               info_in.count_delta   = req_tdata[79:72];
               rd_idx_in     = '0;
               issue_done_in = 1'b0;
               hit_in        = 1'b0;
               free_ok_in    = 1'b0;
               state_in      = FSM_SCAN;
            end
         end
         FSM_SCAN: begin
            // issue the next read while the previous one is compared
            if (!issue_done_ff) begin
               rd_idx_in  = rd_idx_ff + IDX_W'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_idx_ff;
               if (rd_idx_ff == LAST_IDX) begin
                  issue_done_in = 1'b1;
               end
            end
            if (cmp_vld_ff) begin
               if (valid_ff[cmp_idx_ff] &&
                   ram_rdata[crat_pkg::KEY_W-1:0] == info_ff.context_key) begin
                  hit_in     = 1'b1;
                  hit_idx_in = cmp_idx_ff;
                  ent_in     = ram_rdata;
                  state_in   = FSM_UPDATE;
               end else begin
                  // remember the lowest free slot for allocation
                  if (!valid_ff[cmp_idx_ff] && !free_ok_ff) begin
                     free_ok_in  = 1'b1;
                     free_idx_in = cmp_idx_ff;
                  end
                  if (cmp_idx_ff == LAST_IDX) begin
                     state_in = FSM_UPDATE;
                  end
               end
            end
         end
         FSM_UPDATE: begin
            if (upd_go) begin
               rsp_in       = upd_res;
               rsp_valid_in = 1'b1;
               if (upd_ctl.alloc) begin
                  valid_in[free_idx_ff] = 1'b1;
               end
               if (upd_ctl.drop) begin
                  valid_in[hit_idx_ff] = 1'b0;
               end
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_IDLE;
         issue_done_ff <= 1'b0;
         cmp_vld_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         free_ok_ff    <= 1'b0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_done_ff <= issue_done_in;
         cmp_vld_ff    <= cmp_vld_in;
         hit_ff        <= hit_in;
         free_ok_ff    <= free_ok_in;
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      info_ff     <= info_in;
      rd_idx_ff   <= rd_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      ent_ff      <= ent_in;
      rsp_ff      <= rsp_in;
   end

`include "context_refcount_activity_table_assert.svh"

   `CRAT_ASSERT_NEXT(a_accept_starts_scan, clock, reset, req_fire, state_ff == FSM_SCAN)
   `CRAT_ASSERT_IMPL(a_removed_is_empty, clock, reset, rsp_valid_ff && rsp_ff.removed,
                     rsp_ff.status == crat_pkg::STAT_OK && rsp_ff.ref_count == '0)
   `CRAT_ASSERT_IMPL(a_error_no_flags, clock, reset,
                     rsp_valid_ff && rsp_ff.status != crat_pkg::STAT_OK,
                     !rsp_ff.inserted_flag && !rsp_ff.enabled_flag && !rsp_ff.removed)
   `CRAT_ASSERT(a_valid_one_step, clock, reset,
                $countones(valid_ff) <= $countones($past(valid_ff)) + 1)
   `CRAT_ASSERT_IMPL(a_write_in_update, clock, reset, ram_we, state_ff == FSM_UPDATE && !ram_re)

endmodule

`default_nettype wire

>>> bench/tb_context_refcount_activity_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_context_refcount_activity_table
// Drives lookup, enable, disable and refcount commands into the context table
// and checks every response against the scoreboard or a typed directed result.
// ----------------------------------------------------------------------------

module tb_context_refcount_activity_table;

   localparam int ENTRIES     = crat_pkg::DEF_ENTRIES;
   localparam int KINDS       = crat_pkg::DEF_KINDS;
   localparam int POOL_SIZE   = 24;
   localparam int CHUNKS      = 6;
   localparam int CHUNK_ITEMS = 100;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      crat_pkg::cmd_info_type cmd;
      bit                     typed;
      crat_pkg::result_type   want;
   } stim_row_type;

   localparam crat_pkg::result_type NEW_ENTRY   = '{found: 1'b0, ref_count: '0,
      inserted_flag: 1'b1, enabled_flag: 1'b1, removed: 1'b0, status: crat_pkg::STAT_OK};
   localparam crat_pkg::result_type NEW_CLEARED = '{found: 1'b0, ref_count: '0,
      inserted_flag: 1'b0, enabled_flag: 1'b0, removed: 1'b0, status: crat_pkg::STAT_OK};
   localparam crat_pkg::result_type NOT_PRESENT = '{found: 1'b0, ref_count: '0,
      inserted_flag: 1'b0, enabled_flag: 1'b0, removed: 1'b0,
      status: crat_pkg::STAT_NOTFOUND};
   localparam crat_pkg::result_type NO_ROOM     = '{found: 1'b0, ref_count: '0,
      inserted_flag: 1'b0, enabled_flag: 1'b0, removed: 1'b0, status: crat_pkg::STAT_FULL};
   localparam crat_pkg::result_type FREED_ZERO  = '{found: 1'b1, ref_count: '0,
      inserted_flag: 1'b0, enabled_flag: 1'b0, removed: 1'b1, status: crat_pkg::STAT_OK};

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [crat_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [crat_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   // scoreboard copy of the table
   logic                           tbl_valid    [ENTRIES];
   logic [crat_pkg::KEY_W-1:0]     tbl_key      [ENTRIES];
   logic [crat_pkg::COUNT_W-1:0]   tbl_count    [ENTRIES];
   logic [63:0]                    tbl_inserted [ENTRIES];
   logic [63:0]                    tbl_enabled  [ENTRIES];

   crat_pkg::result_type           pending_results_q [$];
   stim_row_type                   directed_rows [$];
   logic [crat_pkg::KEY_W-1:0]     key_pool [POOL_SIZE];

   int unsigned            idle_pct = 30;
   int unsigned            stall_left = 0;
   int unsigned            cycle_count = 0;
   int unsigned            mismatch_count = 0;
   int unsigned            commands_sent = 0;
   int unsigned            results_seen = 0;
   int unsigned            full_seen = 0;
   int unsigned            missing_seen = 0;
   int unsigned            freed_seen = 0;

   context_refcount_activity_table #(
      .ENTRIES(ENTRIES),
      .KINDS  (KINDS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  pending_results_q.size());
         $display("context_refcount_activity_table test failed");
         $finish;
      end
   end

   // response backpressure: rsp_tready held low in random bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         stall_left = $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic crat_pkg::result_type apply_table_command(
      input crat_pkg::cmd_info_type c);
      crat_pkg::result_type         r;
      int                           slot;
      int                           i;
      logic [63:0]                  kind_bit;
      logic [crat_pkg::COUNT_W-1:0] delta_ext;
      r = '0;
      slot = -1;
      kind_bit = (int'(c.activity_kind) < KINDS) ? (64'd1 << c.activity_kind) : 64'd0;
      delta_ext = {{(crat_pkg::COUNT_W-crat_pkg::DELTA_W){c.count_delta[crat_pkg::DELTA_W-1]}},
                   c.count_delta};
      for (i = 0; i < ENTRIES; i++) begin
         if (slot < 0 && tbl_valid[i] && tbl_key[i] == c.context_key) slot = i;
      end
      r.found = (slot >= 0);
      r.status = crat_pkg::STAT_OK;
      if (c.command == crat_pkg::CMD_ENABLE || c.command == crat_pkg::CMD_DISABLE) begin
         // allocate the lowest free entry with everything cleared
         for (i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && !tbl_valid[i]) begin
               slot = i;
               tbl_valid[i] = 1'b1;
               tbl_key[i] = c.context_key;
               tbl_count[i] = '0;
               tbl_inserted[i] = '0;
               tbl_enabled[i] = '0;
            end
         end
         if (slot < 0) begin
            r.status = crat_pkg::STAT_FULL;
         end else if (c.command == crat_pkg::CMD_ENABLE) begin
            tbl_inserted[slot] = tbl_inserted[slot] | kind_bit;
            tbl_enabled[slot] = tbl_enabled[slot] | kind_bit;
         end else begin
            tbl_enabled[slot] = tbl_enabled[slot] & ~kind_bit;
         end
      end else if (slot < 0) begin
         r.status = crat_pkg::STAT_NOTFOUND;
      end else if (c.command == crat_pkg::CMD_REFCOUNT) begin
         tbl_count[slot] = tbl_count[slot] + delta_ext;
         if (tbl_count[slot] == '0) begin
            tbl_valid[slot] = 1'b0;
            r.removed = 1'b1;
            slot = -1;
         end
      end
      if (slot >= 0 && r.status == crat_pkg::STAT_OK) begin
         r.ref_count = tbl_count[slot];
         r.inserted_flag = |(tbl_inserted[slot] & kind_bit);
         r.enabled_flag = |(tbl_enabled[slot] & kind_bit);
      end
      return r;
   endfunction

   task automatic add_row(input logic [crat_pkg::CMD_W-1:0] cmd,
                          input logic [crat_pkg::KEY_W-1:0] key,
                          input int kind, input int delta, input bit typed,
                          input crat_pkg::result_type want);
      stim_row_type row;
      row.cmd.command = cmd;
      row.cmd.context_key = key;
      row.cmd.activity_kind = kind[crat_pkg::KIND_W-1:0];
      row.cmd.count_delta = delta[crat_pkg::DELTA_W-1:0];
      row.typed = typed;
      row.want = want;
      directed_rows.push_back(row);
   endtask

   // present one command and hold it until the transfer; tvalid stays high
   task automatic send_command(input crat_pkg::cmd_info_type c, input bit typed,
                               input crat_pkg::result_type want);
      crat_pkg::result_type predicted;
      req_tdata <= {c.count_delta, c.activity_kind, c.context_key, c.command};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = apply_table_command(c);
      if (predicted.status == crat_pkg::STAT_FULL) full_seen++;
      if (predicted.status == crat_pkg::STAT_NOTFOUND) missing_seen++;
      if (predicted.removed) freed_seen++;
      pending_results_q.push_back(typed ? want : predicted);
      commands_sent++;
   endtask

   task automatic idle_sender(input int unsigned cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic maybe_idle();
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) idle_sender($urandom_range(1, 3));
   endtask

   function automatic crat_pkg::cmd_info_type random_command();
      crat_pkg::cmd_info_type c;
      int unsigned            pick;
      int                     d;
      pick = $urandom_range(0, 99);
      if (pick < 20) c.command = crat_pkg::CMD_LOOKUP;
      else if (pick < 50) c.command = crat_pkg::CMD_ENABLE;
      else if (pick < 65) c.command = crat_pkg::CMD_DISABLE;
      else c.command = crat_pkg::CMD_REFCOUNT;
      if ($urandom_range(0, 99) < 85) c.context_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else c.context_key = {$urandom, $urandom};
      // a few kinds often, so flags set earlier are read back
      if ($urandom_range(0, 1) == 0) c.activity_kind = crat_pkg::KIND_W'($urandom_range(0, 3));
      else c.activity_kind = crat_pkg::KIND_W'($urandom_range(0, 63));
      // small deltas walk counts back to zero
      if ($urandom_range(0, 99) < 60) begin
         d = int'($urandom_range(0, 4)) - 2;
         c.count_delta = d[crat_pkg::DELTA_W-1:0];
      end else begin
         c.count_delta = crat_pkg::DELTA_W'($urandom_range(0, 255));
      end
      return c;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("response %0d: %s", results_seen, msg);
   endtask

   // check each response transfer against the oldest prediction
   always @(posedge clock) begin
      crat_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results_q.size() == 0) begin
            report_mismatch("arrived with nothing pending");
         end else begin
            want = pending_results_q.pop_front();
            if (rsp_tdata[0] !== want.found)
               report_mismatch($sformatf("found expected %0h, got %0h",
                                         want.found, rsp_tdata[0]));
            if (rsp_tdata[32:1] !== want.ref_count)
               report_mismatch($sformatf("ref_count expected %0h, got %0h",
                                         want.ref_count, rsp_tdata[32:1]));
            if (rsp_tdata[33] !== want.inserted_flag)
               report_mismatch($sformatf("inserted_flag expected %0h, got %0h",
                                         want.inserted_flag, rsp_tdata[33]));
            if (rsp_tdata[34] !== want.enabled_flag)
               report_mismatch($sformatf("enabled_flag expected %0h, got %0h",
                                         want.enabled_flag, rsp_tdata[34]));
            if (rsp_tdata[35] !== want.removed)
               report_mismatch($sformatf("removed expected %0h, got %0h",
                                         want.removed, rsp_tdata[35]));
            if (rsp_tdata[37:36] !== want.status)
               report_mismatch($sformatf("status expected %0h, got %0h",
                                         want.status, rsp_tdata[37:36]));
         end
         results_seen++;
      end
   end

   initial begin
      int i;
      int chunk;
      int n;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      for (i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;

      add_row(crat_pkg::CMD_LOOKUP,   '0, 0, 0, 1'b1, NOT_PRESENT);
      add_row(crat_pkg::CMD_REFCOUNT, '1, 63, -128, 1'b1, NOT_PRESENT);
      add_row(crat_pkg::CMD_ENABLE,   '0, 0, 0, 1'b1, NEW_ENTRY);
      add_row(crat_pkg::CMD_ENABLE,   '1, 63, 0, 1'b1, NEW_ENTRY);
      add_row(crat_pkg::CMD_LOOKUP,   '1, 63, 127, 1'b0, NEW_ENTRY);
      add_row(crat_pkg::CMD_DISABLE,  '0, 0, 0, 1'b0, NEW_ENTRY);
      add_row(crat_pkg::CMD_REFCOUNT, '0, 0, 127, 1'b0, NEW_ENTRY);
      // wrap below zero, then step back up to zero
      add_row(crat_pkg::CMD_REFCOUNT, '0, 0, -128, 1'b0, NEW_ENTRY);
      add_row(crat_pkg::CMD_REFCOUNT, '0, 0, 1, 1'b0, NEW_ENTRY);
      add_row(crat_pkg::CMD_REFCOUNT, '1, 63, 0, 1'b1, FREED_ZERO);
      add_row(crat_pkg::CMD_DISABLE,  64'h5a5a_a5a5_0f0f_f0f0, 5, 0, 1'b1, NEW_CLEARED);
      for (i = 1; i < ENTRIES; i++)
         add_row(crat_pkg::CMD_ENABLE, 64'h1000 + i, i, 0, 1'b1, NEW_ENTRY);
      add_row(crat_pkg::CMD_ENABLE,   64'hdead_0000_0000_beef, 7, 0, 1'b1, NO_ROOM);
      add_row(crat_pkg::CMD_DISABLE,  64'h8000_0000_0000_0000, 62, 0, 1'b1, NO_ROOM);

      // pool keeps the directed residents so they can be drained later
      key_pool[0] = 64'h5a5a_a5a5_0f0f_f0f0;
      for (i = 1; i < ENTRIES; i++) key_pool[i] = 64'h1000 + i;
      key_pool[ENTRIES] = '0;
      key_pool[ENTRIES + 1] = '1;
      for (i = ENTRIES + 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < directed_rows.size(); i++) begin
         send_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
         maybe_idle();
      end

      for (chunk = 0; chunk < CHUNKS; chunk++) begin
         case (chunk)
            0: idle_pct = 15;
            1: idle_pct = 0;
            2: idle_pct = 40;
            3: idle_pct = 25;
            4: idle_pct = 10;
            default: idle_pct = 0;
         endcase
         if (chunk == 3) begin
            // drain the table pipeline before resuming
            idle_sender(1);
            while (pending_results_q.size() != 0) @(posedge clock);
         end
         for (n = 0; n < CHUNK_ITEMS; n++) begin
            send_command(random_command(), 1'b0, NO_ROOM);
            maybe_idle();
         end
      end
      idle_sender(1);

      while (pending_results_q.size() != 0) @(posedge clock);
      repeat (ENTRIES + 8) @(posedge clock);

      $display("sent %0d commands, checked %0d responses", commands_sent, results_seen);
      $display("covered %0d table-full, %0d missing-context and %0d freed-entry cases",
               full_seen, missing_seen, freed_seen);
      if (mismatch_count == 0) begin
         $display("context_refcount_activity_table test passed");
      end else begin
         $display("context_refcount_activity_table test failed");
      end
      $finish;
   end

endmodule
